// File: sv/tcch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_pkg
// Shared types, widths and the arctangent table for the compass heading block.
// ----------------------------------------------------------------------------
package tcch_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TAB_IDX_W    = 5;

    localparam int CW   = 60;
    localparam int ZW   = 27;
    localparam int MA_W = 22;
    localparam int MB_W = 17;
    localparam int MP_W = MA_W + MB_W;
    localparam int OFS_W = 19;
    localparam int SC_W  = 17;

    localparam logic [14:0] EXTENT_RESET = 15'd2180;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 60'sd652032875;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFS,
        S_SCP_GO,
        S_SCP_RUN,
        S_SCR_GO,
        S_SCR_RUN,
        S_MUL,
        S_AT_GO,
        S_AT_RUN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_ctl;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 27'sd1152000;
            5'd1:  v = 27'sd680065;
            5'd2:  v = 27'sd359328;
            5'd3:  v = 27'sd182400;
            5'd4:  v = 27'sd91554;
            5'd5:  v = 27'sd45822;
            5'd6:  v = 27'sd22916;
            5'd7:  v = 27'sd11459;
            5'd8:  v = 27'sd5730;
            5'd9:  v = 27'sd2865;
            5'd10: v = 27'sd1432;
            5'd11: v = 27'sd716;
            5'd12: v = 27'sd358;
            5'd13: v = 27'sd179;
            5'd14: v = 27'sd90;
            5'd15: v = 27'sd45;
            5'd16: v = 27'sd22;
            5'd17: v = 27'sd11;
            5'd18: v = 27'sd6;
            5'd19: v = 27'sd3;
            5'd20: v = 27'sd1;
            5'd21: v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/tilt_compensated_compass_heading.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading
// Hard-iron offset tracking, tilt compensation and heading from one
// magnetometer sample and attitude angles.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     i_valid, o_stall, i_mag_*, i_attitude_*   in
//  output    o_valid, i_stall, o_heading_cdeg          out
//  config    i_cfg_wr_en, i_cfg_wr_data                in
//
//  An item passes through the offset, pitch and roll sine/cosine, multiply,
//  heading and output states: three CORDIC runs on the single shared engine,
//  the products on the shared multiplier. The heading run is skipped when both
//  heading terms are zero. The next item is taken in the idle state after output.
//  The input is stalled while an item is in work; a finished result waits in
//  the output register and a new item may be taken meanwhile. A result that
//  finds the output register still stalled holds the sequencer until it frees.
//  Reset is synchronous; it loads the trackers from extent 2180.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_mag_x_raw,
    input  logic signed [15:0] i_mag_y_raw,
    input  logic signed [15:0] i_mag_z_raw,
    input  logic signed [15:0] i_attitude_pitch_cdeg,
    input  logic signed [15:0] i_attitude_roll_cdeg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_heading_cdeg,
    input  logic               i_cfg_wr_en,
    input  logic [14:0]        i_cfg_wr_data
);
    import tcch_pkg::*;

    t_state r_state, n_state;

    logic signed [15:0]    r_max [3];
    logic signed [15:0]    r_min [3];
    logic signed [15:0]    r_raw [3];
    logic signed [OFS_W-1:0] r_m [3];
    logic signed [16:0]    r_roll, r_pitch;
    logic                  r_flip;
    logic signed [SC_W-1:0] r_cp, r_sp, r_cr, r_sr;
    logic [2:0]            r_mstep;
    logic signed [MP_W-1:0] r_u, r_hy;
    logic signed [CW-1:0]  r_hx;
    logic signed [15:0]    r_head, r_out;
    logic                  r_ovalid;

    logic                  w_in_acc, w_out_free;
    logic signed [15:0]    w_raw [3];
    t_cordic_ctl           w_cctl;
    logic signed [CW-1:0]  w_cx, w_cy, c_x, c_y;
    logic signed [ZW-1:0]  w_cz, c_z;
    logic                  c_busy, c_done;
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    logic signed [MP_W-1:0] m_p;
    logic signed [17:0]    w_ang;
    logic                  w_flip;
    logic signed [CW-1:0]  w_ax, w_ay, w_xr, w_yr, w_hy_s;
    logic signed [SC_W-1:0] w_cos, w_sin;
    logic signed [ZW-1:0]  w_zr;
    logic                  w_zero;

    tcch_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cctl),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_z     (w_cz),
        .o_busy  (c_busy),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    tcch_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (m_p)
    );

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        w_raw[0] = 16'(signed'(i_mag_x_raw[SAMPLE_BITS-1:0]));
        w_raw[1] = 16'(signed'(i_mag_y_raw[SAMPLE_BITS-1:0]));
        w_raw[2] = 16'(signed'(i_mag_z_raw[SAMPLE_BITS-1:0]));
    end

    // angle reduction for sine/cosine
    always_comb begin
        w_ang  = (r_state == S_SCP_GO) ? 18'(r_pitch) : 18'(r_roll);
        w_flip = 1'b0;
        if (w_ang > 18'sd18000) w_ang = w_ang - 18'sd36000;
        if (w_ang < -18'sd18000) w_ang = w_ang + 18'sd36000;
        if (w_ang > 18'sd9000) begin
            w_ang  = w_ang - 18'sd18000;
            w_flip = 1'b1;
        end else if (w_ang < -18'sd9000) begin
            w_ang  = w_ang + 18'sd18000;
            w_flip = 1'b1;
        end
    end

    // round and saturate sine/cosine
    always_comb begin
        w_xr = (c_x + CW'(16384)) >>> 15;
        w_yr = (c_y + CW'(16384)) >>> 15;
        if (w_xr > CW'(32767)) w_cos = SC_W'(32767);
        else if (w_xr < -CW'(32768)) w_cos = -SC_W'(32768);
        else w_cos = SC_W'(w_xr);
        if (w_yr > CW'(32767)) w_sin = SC_W'(32767);
        else if (w_yr < -CW'(32768)) w_sin = -SC_W'(32768);
        else w_sin = SC_W'(w_yr);
        if (r_flip) begin
            w_cos = -w_cos;
            w_sin = -w_sin;
        end
    end

    // atan2 set-up with quarter-turn pre-rotation
    always_comb begin
        w_hy_s = -(CW'(r_hy) <<< 15);
        w_zero = (r_hx == '0) && (w_hy_s == '0);
        w_ax   = r_hx;
        w_ay   = w_hy_s;
        w_zr   = '0;
        if (r_hx[CW-1]) begin
            if (!w_hy_s[CW-1]) begin
                w_ax = w_hy_s;
                w_ay = -r_hx;
                w_zr = ZW'(9000 * 256);
            end else begin
                w_ax = -w_hy_s;
                w_ay = r_hx;
                w_zr = -ZW'(9000 * 256);
            end
        end
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_mstep)
            3'd0: begin w_ma = MA_W'(r_m[0]); w_mb = r_cp; end
            3'd1: begin w_ma = MA_W'(r_m[1]); w_mb = r_sr; end
            3'd2: begin w_ma = MA_W'(r_m[2]); w_mb = r_cr; end
            3'd3: begin w_ma = MA_W'(r_m[1]); w_mb = r_cr; end
            3'd4: begin w_ma = r_u[MA_W+15:16]; w_mb = r_sp; end
            3'd5: begin w_ma = MA_W'({1'b0, r_u[15:0]}); w_mb = r_sp; end
            3'd6: begin w_ma = MA_W'(r_m[2]); w_mb = r_sr; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_in_acc) n_state = S_OFFS;
            S_OFFS:    n_state = S_SCP_GO;
            S_SCP_GO:  n_state = S_SCP_RUN;
            S_SCP_RUN: if (c_done) n_state = S_SCR_GO;
            S_SCR_GO:  n_state = S_SCR_RUN;
            S_SCR_RUN: if (c_done) n_state = S_MUL;
            S_MUL:     if (r_mstep == 3'd7) n_state = S_AT_GO;
            S_AT_GO:   n_state = w_zero ? S_OUT : S_AT_RUN;
            S_AT_RUN:  if (c_done) n_state = S_OUT;
            S_OUT:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall       = 1'b1;
        w_cctl.start  = 1'b0;
        w_cctl.rotate = 1'b1;
        w_cx          = INV_GAIN_Q30;
        w_cy          = '0;
        w_cz          = ZW'(w_ang) <<< 8;
        case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_SCP_GO, S_SCR_GO: w_cctl.start = 1'b1;
            S_AT_GO: begin
                w_cctl.start  = !w_zero;
                w_cctl.rotate = 1'b0;
                w_cx          = w_ax;
                w_cy          = w_ay;
                w_cz          = w_zr;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_max[i] <= -16'(EXTENT_RESET);
                r_min[i] <= 16'(EXTENT_RESET);
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_wr_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_max[i] <= -16'(i_cfg_wr_data);
                    r_min[i] <= 16'(i_cfg_wr_data);
                end
            end else if (w_in_acc) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_raw[i] > r_max[i]) r_max[i] <= w_raw[i];
                    if (w_raw[i] < r_min[i]) r_min[i] <= w_raw[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw   <= w_raw;
            r_roll  <= 17'(i_attitude_pitch_cdeg);
            r_pitch <= -17'(i_attitude_roll_cdeg);
        end
        case (r_state)
            S_OFFS: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= (OFS_W'(r_raw[i]) <<< 1) - (OFS_W'(r_max[i]) + OFS_W'(r_min[i]));
                end
                r_mstep <= '0;
            end
            S_SCP_GO, S_SCR_GO: r_flip <= w_flip;
            S_SCP_RUN: if (c_done) begin
                r_cp <= w_cos;
                r_sp <= w_sin;
            end
            S_SCR_RUN: if (c_done) begin
                r_cr <= w_cos;
                r_sr <= w_sin;
            end
            S_MUL: begin
                r_mstep <= r_mstep + 1'b1;
                case (r_mstep)
                    3'd1: r_hx <= CW'(m_p) <<< 15;
                    3'd2: r_u  <= m_p;
                    3'd3: r_u  <= r_u + m_p;
                    3'd4: r_hy <= m_p;
                    3'd5: r_hx <= r_hx + (CW'(m_p) <<< 16);
                    3'd6: r_hx <= r_hx + CW'(m_p);
                    3'd7: r_hy <= r_hy - m_p;
                    default: r_hx <= r_hx;
                endcase
            end
            S_AT_GO: r_head <= '0;
            S_AT_RUN: if (c_done) begin
                if (((c_z + ZW'(128)) >>> 8) > ZW'(18000)) r_head <= 16'sd18000;
                else if (((c_z + ZW'(128)) >>> 8) < -ZW'(18000)) r_head <= -16'sd18000;
                else r_head <= 16'((c_z + ZW'(128)) >>> 8);
            end
            default: r_head <= r_head;
        endcase
        if (r_state == S_OUT && w_out_free) r_out <= r_head;
    end

    assign o_valid        = r_ovalid;
    assign o_heading_cdeg = r_out;

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_accept_offs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_OFFS))
        else $error("accepted item not started");
    a_cordic_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_busy |-> (r_state == S_SCP_RUN || r_state == S_SCR_RUN || r_state == S_AT_RUN))
        else $error("cordic running outside a run state");
`endif

endmodule

// File: sv/tcch_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_cordic
// Shared CORDIC engine, rotation or vectoring mode, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module tcch_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcch_pkg::t_cordic_ctl             i_ctl,
    input  logic signed [tcch_pkg::CW-1:0]    i_x,
    input  logic signed [tcch_pkg::CW-1:0]    i_y,
    input  logic signed [tcch_pkg::ZW-1:0]    i_z,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [tcch_pkg::CW-1:0]    o_x,
    output logic signed [tcch_pkg::CW-1:0]    o_y,
    output logic signed [tcch_pkg::ZW-1:0]    o_z
);
    import tcch_pkg::*;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [STEP_W-1:0]    r_step;
    logic                 r_busy, r_done, r_rot;
    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_t;
    logic                 w_neg;

    always_comb begin
        w_xs  = r_x >>> r_step;
        w_ys  = r_y >>> r_step;
        w_t   = atan_tab(TAB_IDX_W'(r_step));
        w_neg = r_rot ? !r_z[ZW-1] : r_y[CW-1];
        if (w_neg) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_t;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_rot <= i_ctl.rotate;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// File: sv/tcch_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tcch_mul (
    input  logic                               i_clk,
    input  logic signed [tcch_pkg::MA_W-1:0]   i_a,
    input  logic signed [tcch_pkg::MB_W-1:0]   i_b,
    output logic signed [tcch_pkg::MP_W-1:0]   o_p
);
    import tcch_pkg::*;

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;

endmodule
